/* design/cwm_pkg.sv */
// Types and codes shared by the control point warp map block.
// Holds no parameters and depends on no other file.
package cwm_pkg;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_MAP   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] MODE_TRANSLATE = 2'd2;

   typedef struct packed {
      logic [11:0]        cx;
      logic [11:0]        cy;
      logic [11:0]        rad;
      logic signed [12:0] sx;
      logic signed [12:0] sy;
      logic [1:0]         mode;
   } ctl_type;

   typedef struct packed {
      logic insert;
      logic rotate;
   } cell_ctl_type;

endpackage

/* design/cwm_cell.sv */
// One storage cell of the control chain: holds one warp control.
// Depends on cwm_pkg for the control record and the cell command struct.
module cwm_cell (
   input  logic                 clock,
   input  cwm_pkg::cell_ctl_type cmd,
   input  cwm_pkg::ctl_type     ins_d,
   input  cwm_pkg::ctl_type     rot_d,
   output cwm_pkg::ctl_type     q
);
   import cwm_pkg::*;

   ctl_type ctl_ff;
   ctl_type ctl_in;

   always_comb begin
      priority if (cmd.insert) begin
         ctl_in = ins_d;
      end else if (cmd.rotate) begin
         ctl_in = rot_d;
      end else begin
         ctl_in = ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff <= ctl_in;
   end

   assign q = ctl_ff;

endmodule

/* design/cwm_unit.sv */
// Iterative arithmetic unit: applies one warp control to a source coordinate.
// Uses one shared multiplier and a bit-serial divider. Depends on cwm_pkg.
module cwm_unit #(
   parameter int FW = 21
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cwm_pkg::ctl_type     ctl,
   input  logic signed [FW-1:0] fu,
   input  logic signed [FW-1:0] fv,
   input  logic                 start,
   output logic                 done,
   output logic signed [FW-1:0] fu_out,
   output logic signed [FW-1:0] fv_out
);
   import cwm_pkg::*;

   localparam int DW  = ((FW > 21) ? FW : 21) + 2;
   localparam int PW  = 2 * DW;
   localparam int SQW = PW + 1;
   localparam int RW  = SQW + 2;
   localparam logic signed [DW-1:0] SMAX = DW'((2 ** (FW - 1)) - 1);
   localparam logic signed [DW-1:0] SMIN = -SMAX - DW'(1);

   localparam logic [2:0] U_IDLE = 3'd0;
   localparam logic [2:0] U_DIFF = 3'd1;
   localparam logic [2:0] U_SQ   = 3'd2;
   localparam logic [2:0] U_CMP  = 3'd3;
   localparam logic [2:0] U_DIV  = 3'd4;
   localparam logic [2:0] U_AA   = 3'd5;
   localparam logic [2:0] U_MU   = 3'd6;
   localparam logic [2:0] U_MV   = 3'd7;

   function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
      return v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   function automatic logic signed [FW-1:0] sat(input logic signed [DW-1:0] v);
      logic signed [DW-1:0] r;
      r = v;
      if (v > SMAX) r = SMAX;
      if (v < SMIN) r = SMIN;
      return r[FW-1:0];
   endfunction

   logic [2:0]            step_ff, step_in;
   logic [2:0]            sel_ff, sel_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic signed [DW-1:0]  dx_ff, dx_in, dy_ff, dy_in, mx_ff, mx_in, my_ff, my_in;
   logic signed [DW-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic signed [FW-1:0]  fu_ff, fu_in, fv_ff, fv_in;
   logic [SQW-1:0]        rsq_ff, rsq_in, msq_ff, msq_in, maxsq_ff, maxsq_in;
   logic [SQW:0]          den_ff, den_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [15:0]           q_ff, q_in, w_ff, w_in;

   logic [DW-1:0]         op_a, op_b;
   logic [PW-1:0]         prod;
   logic [RW-1:0]         rem2;
   logic [SQW-1:0]        num;
   logic [DW-1:0]         mv;
   logic signed [DW-1:0]  delta;
   logic signed [DW-1:0]  base;

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (step_ff)
         U_SQ: begin
            unique case (sel_ff)
               3'd0:    op_a = mag(dx_ff);
               3'd1:    op_a = mag(dy_ff);
               3'd2:    op_a = mag(mx_ff);
               3'd3:    op_a = mag(my_ff);
               default: op_a = DW'(ctl.rad);
            endcase
            op_b = op_a;
         end
         U_AA: begin
            op_a = DW'(q_ff);
            op_b = DW'(q_ff);
         end
         U_MU: begin
            op_a = DW'(w_ff);
            op_b = mag(sx_ff);
         end
         U_MV: begin
            op_a = DW'(w_ff);
            op_b = mag(sy_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod = PW'(op_a) * PW'(op_b);
   assign rem2 = rem_ff << 1;
   assign num  = maxsq_ff - rsq_ff;
   assign mv   = DW'(prod >> 16);

   always_comb begin
      step_in  = step_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      fu_in    = fu_ff;
      fv_in    = fv_ff;
      rsq_in   = rsq_ff;
      msq_in   = msq_ff;
      maxsq_in = maxsq_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      w_in     = w_ff;
      delta    = '0;
      base     = '0;
      unique case (step_ff)
         U_IDLE: begin
            if (start) begin
               fu_in = fu;
               fv_in = fv;
               dx_in = {{(DW-FW){fu[FW-1]}}, fu} - signed'(DW'({ctl.cx, 8'h00}));
               dy_in = {{(DW-FW){fv[FW-1]}}, fv} - signed'(DW'({ctl.cy, 8'h00}));
               sx_in = {{(DW-21){ctl.sx[12]}}, ctl.sx, 8'h00};
               sy_in = {{(DW-21){ctl.sy[12]}}, ctl.sy, 8'h00};
               if (ctl.mode == MODE_TRANSLATE) begin
                  step_in = U_DIFF;
               end else begin
                  done_in = 1'b1;
               end
            end
         end
         U_DIFF: begin
            mx_in   = dx_ff - sx_ff;
            my_in   = dy_ff - sy_ff;
            sel_in  = 3'd0;
            step_in = U_SQ;
         end
         U_SQ: begin
            unique case (sel_ff)
               3'd0:    rsq_in   = SQW'(prod);
               3'd1:    rsq_in   = rsq_ff + SQW'(prod);
               3'd2:    msq_in   = SQW'(prod);
               3'd3:    msq_in   = msq_ff + SQW'(prod);
               default: maxsq_in = SQW'(prod) << 16;
            endcase
            sel_in = sel_ff + 3'd1;
            if (sel_ff == 3'd4) begin
               step_in = U_CMP;
            end
         end
         U_CMP: begin
            if (rsq_ff >= maxsq_ff) begin
               done_in = 1'b1;
               step_in = U_IDLE;
            end else begin
               den_in  = (SQW+1)'(num) + (SQW+1)'(msq_ff);
               rem_in  = RW'(num);
               q_in    = '0;
               cnt_in  = '0;
               step_in = U_DIV;
            end
         end
         U_DIV: begin
            if (rem2 >= RW'(den_ff)) begin
               rem_in = rem2 - RW'(den_ff);
               q_in   = {q_ff[14:0], 1'b1};
            end else begin
               rem_in = rem2;
               q_in   = {q_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               step_in = U_AA;
            end
         end
         U_AA: begin
            w_in    = prod[31:16];
            step_in = U_MU;
         end
         U_MU: begin
            delta   = sx_ff[DW-1] ? -signed'(mv) : signed'(mv);
            base    = {{(DW-FW){fu_ff[FW-1]}}, fu_ff};
            fu_in   = sat(base - delta);
            step_in = U_MV;
         end
         default: begin
            delta   = sy_ff[DW-1] ? -signed'(mv) : signed'(mv);
            base    = {{(DW-FW){fv_ff[FW-1]}}, fv_ff};
            fv_in   = sat(base - delta);
            done_in = 1'b1;
            step_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= U_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      sel_ff   <= sel_in;
      cnt_ff   <= cnt_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      fu_ff    <= fu_in;
      fv_ff    <= fv_in;
      rsq_ff   <= rsq_in;
      msq_ff   <= msq_in;
      maxsq_ff <= maxsq_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      w_ff     <= w_in;
   end

   assign done   = done_ff;
   assign fu_out = fu_ff;
   assign fv_out = fv_ff;

endmodule

/* design/control_point_image_warp_map_top.sv */
// Top level of the control point warp map: control chain, walk sequencer, result register.
// Depends on cwm_pkg, cwm_cell and cwm_unit.
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_stall  kind, pos_x, pos_y, reach, shift, warp_mode
//   rsp_      out         rsp_valid/rsp_stall  src_u, src_v (signed Q.8)
//
// Add and clear beats complete in ST_IDLE. A map beat walks all MAX_CONTROLS cells: a cell
// past the stored count is only rotated, a stored control of another mode is passed over by
// the unit, and a translate control is tested against its disc and, if the disc covers the
// point, applied through the shared multiplier and the 16-step divider. The walk then passes
// through ST_DONE, which loads the result. Reset empties the table. A waiting result does not block the next beat;
// a map finishing while the result register is full waits.
module control_point_image_warp_map_top #(
   parameter int MAX_CONTROLS = 16,
   parameter int COORD_BITS   = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_kind,
   input  logic [11:0]                    req_pos_x,
   input  logic [11:0]                    req_pos_y,
   input  logic [11:0]                    req_reach,
   input  logic signed [12:0]             req_shift_x,
   input  logic signed [12:0]             req_shift_y,
   input  logic [1:0]                     req_warp_mode,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [COORD_BITS+8:0]   rsp_src_u,
   output logic signed [COORD_BITS+8:0]   rsp_src_v
);
   import cwm_pkg::*;

   localparam int FW = COORD_BITS + 9;
   localparam int CW = $clog2(MAX_CONTROLS + 1);
   localparam int TW = (FW > 21) ? FW : 21;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_CONTROLS);
   localparam logic [TW-1:0] UMAX  = TW'((2 ** (FW - 1)) - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_BUSY = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic signed [FW-1:0] fu_ff, fu_in, fv_ff, fv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [FW-1:0] src_u_ff, src_u_in, src_v_ff, src_v_in;

   logic                 accept;
   logic                 rotate;
   logic                 unit_start;
   logic                 unit_done;
   logic signed [FW-1:0] unit_fu, unit_fv;
   logic [TW-1:0]        px8, py8;
   cell_ctl_type         cell_cmd;
   ctl_type              new_ctl;
   ctl_type              cell_q [MAX_CONTROLS];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign px8       = TW'({req_pos_x, 8'h00});
   assign py8       = TW'({req_pos_y, 8'h00});

   assign new_ctl.cx   = req_pos_x;
   assign new_ctl.cy   = req_pos_y;
   assign new_ctl.rad  = req_reach;
   assign new_ctl.sx   = req_shift_x;
   assign new_ctl.sy   = req_shift_y;
   assign new_ctl.mode = req_warp_mode;

   assign cell_cmd.insert = accept && (req_kind == KIND_ADD) && (cnt_ff < MAX_C);
   assign cell_cmd.rotate = rotate;

   for (genvar i = 0; i < MAX_CONTROLS; i++) begin : g_chain
      ctl_type ins_src;
      if (i == 0) begin : g_head
         assign ins_src = new_ctl;
      end else begin : g_body
         assign ins_src = cell_q[i-1];
      end
      cwm_cell u_cell (
         .clock (clock),
         .cmd   (cell_cmd),
         .ins_d (ins_src),
         .rot_d (cell_q[(i + 1) % MAX_CONTROLS]),
         .q     (cell_q[i])
      );
   end

   cwm_unit #(.FW(FW)) u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctl    (cell_q[0]),
      .fu     (fu_ff),
      .fv     (fv_ff),
      .start  (unit_start),
      .done   (unit_done),
      .fu_out (unit_fu),
      .fv_out (unit_fv)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      fu_in        = fu_ff;
      fv_in        = fv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      src_u_in     = src_u_ff;
      src_v_in     = src_v_ff;
      rotate       = 1'b0;
      unit_start   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_ADD: begin
                     if (cnt_ff < MAX_C) begin
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  KIND_CLEAR: begin
                     cnt_in = '0;
                  end
                  KIND_MAP: begin
                     fu_in    = signed'((px8 > UMAX) ? FW'(UMAX) : FW'(px8));
                     fv_in    = signed'((py8 > UMAX) ? FW'(UMAX) : FW'(py8));
                     idx_in   = '0;
                     state_in = ST_WALK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_WALK: begin
            priority if (idx_ff == MAX_C) begin
               state_in = ST_DONE;
            end else if (idx_ff < cnt_ff) begin
               unit_start = 1'b1;
               state_in   = ST_BUSY;
            end else begin
               rotate = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_BUSY: begin
            if (unit_done) begin
               fu_in    = unit_fu;
               fv_in    = unit_fv;
               rotate   = 1'b1;
               idx_in   = idx_ff + CW'(1);
               state_in = ST_WALK;
            end
         end
         default: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               src_u_in     = fu_ff;
               src_v_in     = fv_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fu_ff    <= fu_in;
      fv_ff    <= fv_in;
      src_u_ff <= src_u_in;
      src_v_ff <= src_v_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_src_u = src_u_ff;
   assign rsp_src_v = src_v_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_C) else $error("control count exceeds table size");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= MAX_C) else $error("walk index beyond chain");

   a_map_walk: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_MAP) |=> state_ff == ST_WALK)
      else $error("map beat did not start a walk");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> state_ff == ST_BUSY) else $error("unit finished outside a walk");

endmodule
